>>> src/tsqb_pkg.sv
// Shared types and constants for the threshold select block with quintic blend.
// Depends on nothing; every other file refers to it by scoped names.
package tsqb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-2:0] falloff_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FRAC_BITS:0] fade_t;

  typedef enum logic [1:0] {
    MODE_LOW,
    MODE_HIGH,
    MODE_BLEND
  } mode_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_FALLOFF   = 1'b1
  } reg_index_t;

  typedef struct packed {
    mode_t   mode;
    sample_t lo;
    sample_t hi;
  } side_t;

endpackage

>>> src/tsqb_front.sv
// Input stage: compares the control sample against the band edges and forms the
// distance from the lower edge. Depends on tsqb_pkg.
module tsqb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  tsqb_pkg::sample_t    control_value,
  input  tsqb_pkg::sample_t    low_value,
  input  tsqb_pkg::sample_t    high_value,
  input  tsqb_pkg::sample_t    threshold,
  input  tsqb_pkg::falloff_t   falloff,
  output logic                 out_vld,
  output tsqb_pkg::side_t      out_side,
  output logic [tsqb_pkg::SAMPLE_BITS-1:0] offset,
  output logic                 sat
);

  localparam int SB = tsqb_pkg::SAMPLE_BITS;
  localparam int EW = SB + 2;

  logic signed [EW-1:0] n_ext;
  logic signed [EW-1:0] thr_ext;
  logic signed [EW-1:0] fo_ext;
  logic signed [EW-1:0] upper;
  logic signed [EW-1:0] lower;
  logic signed [EW-1:0] d_full;
  tsqb_pkg::mode_t      mode_next;

  assign n_ext   = EW'(control_value);
  assign thr_ext = EW'(threshold);
  assign fo_ext  = $signed(EW'(falloff));
  assign upper   = thr_ext + fo_ext;
  assign lower   = thr_ext - fo_ext;
  assign d_full  = n_ext - lower;

  always_comb begin
    if (n_ext > upper) begin
      mode_next = tsqb_pkg::MODE_HIGH;
    end else if (n_ext < lower) begin
      mode_next = tsqb_pkg::MODE_LOW;
    end else if (falloff == '0) begin
      mode_next = tsqb_pkg::MODE_LOW;
    end else begin
      mode_next = tsqb_pkg::MODE_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side.mode <= mode_next;
      out_side.lo   <= low_value;
      out_side.hi   <= high_value;
      offset        <= d_full[SB-1:0];
      sat           <= (n_ext == upper);
    end
  end

`ifndef NO_ASSERTIONS
  a_band_distance: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_side.mode == tsqb_pkg::MODE_BLEND && !sat
      |-> offset < {falloff, 1'b0})
    else $error("blend request with distance outside the band");
`endif

endmodule

>>> src/tsqb_div.sv
// Restoring divider, one quotient bit per register stage, giving the blend
// factor in Q0.16. Depends on tsqb_pkg.
module tsqb_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  tsqb_pkg::side_t      in_side,
  input  logic [tsqb_pkg::SAMPLE_BITS-1:0] offset,
  input  logic                 sat,
  input  tsqb_pkg::falloff_t   falloff,
  output logic                 out_vld,
  output tsqb_pkg::side_t      out_side,
  output tsqb_pkg::frac_t      t
);

  localparam int SB = tsqb_pkg::SAMPLE_BITS;
  localparam int NS = tsqb_pkg::FRAC_BITS;

  logic            vld  [NS+1];
  tsqb_pkg::side_t side [NS+1];
  logic [SB-1:0]   rem  [NS+1];
  tsqb_pkg::frac_t quo  [NS+1];
  logic            satp [NS+1];
  logic [SB-1:0]   den;

  assign den     = {falloff, 1'b0};
  assign vld[0]  = in_vld;
  assign side[0] = in_side;
  assign rem[0]  = offset;
  assign quo[0]  = '0;
  assign satp[0] = sat;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [SB:0] dbl;
    logic [SB:0] sub;
    logic        ge;

    assign dbl = {rem[k], 1'b0};
    assign sub = dbl - {1'b0, den};
    assign ge  = dbl >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= ge ? sub[SB-1:0] : dbl[SB-1:0];
        quo[k+1]  <= {quo[k][NS-2:0], ge};
        side[k+1] <= side[k];
        satp[k+1] <= satp[k];
      end
    end
  end

  assign out_vld  = vld[NS];
  assign out_side = side[NS];
  assign t        = satp[NS] ? '1 : quo[NS];

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    vld[NS] && side[NS].mode == tsqb_pkg::MODE_BLEND && !satp[NS]
      |-> rem[NS] < den)
    else $error("divider remainder not below the divisor");
`endif

endmodule

>>> src/tsqb_fade.sv
// Quintic fade 6t^5 - 15t^4 + 10t^3 in three register stages, one multiplier of
// two variables in each. Depends on tsqb_pkg.
module tsqb_fade (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  tsqb_pkg::side_t      in_side,
  input  tsqb_pkg::frac_t      t,
  output logic                 out_vld,
  output tsqb_pkg::side_t      out_side,
  output tsqb_pkg::fade_t      f
);

  localparam int FB = tsqb_pkg::FRAC_BITS;
  localparam int PW = FB + 5;
  localparam logic [PW-1:0] TEN   = PW'(10) << FB;
  localparam logic [PW-1:0] ONE_W = PW'(1) << FB;

  logic            s1_vld;
  logic            s2_vld;
  tsqb_pkg::side_t s1_side;
  tsqb_pkg::side_t s2_side;
  tsqb_pkg::frac_t s1_t;
  tsqb_pkg::frac_t s1_t2;
  tsqb_pkg::frac_t s2_t3;
  logic [PW-1:0]   s2_p;

  logic [2*FB-1:0] sq;
  logic [2*FB-1:0] cube;
  logic [PW-1:0]   pos;
  logic [PW-1:0]   neg;
  logic [FB+PW-1:0] full;
  logic [PW-1:0]   scaled;

  assign sq     = (2*FB)'(t) * (2*FB)'(t);
  assign cube   = (2*FB)'(s1_t2) * (2*FB)'(s1_t);
  assign pos    = PW'(s1_t2) * PW'(6) + TEN;
  assign neg    = PW'(s1_t) * PW'(15);
  assign full   = (FB+PW)'(s2_t3) * (FB+PW)'(s2_p);
  assign scaled = full[FB+PW-1:FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      out_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side  <= in_side;
      s1_t     <= t;
      s1_t2    <= sq[2*FB-1:FB];
      s2_side  <= s1_side;
      s2_t3    <= cube[2*FB-1:FB];
      s2_p     <= (pos < neg) ? '0 : pos - neg;
      out_side <= s2_side;
      f        <= (scaled > ONE_W) ? ONE_W[FB:0] : scaled[FB:0];
    end
  end

endmodule

>>> src/tsqb_mix.sv
// Interpolation from the low toward the high sample, rounding, saturation, the
// choice of low, high or blend by mode and the output register. Depends on tsqb_pkg.
module tsqb_mix (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  tsqb_pkg::side_t      in_side,
  input  tsqb_pkg::fade_t      f,
  output logic                 out_vld,
  output tsqb_pkg::sample_t    result
);

  localparam int SB = tsqb_pkg::SAMPLE_BITS;
  localparam int FB = tsqb_pkg::FRAC_BITS;
  localparam int MW = FB + SB + 3;
  localparam int RW = SB + 4;
  localparam logic signed [MW-1:0] HALF = MW'(1) << (FB - 1);
  localparam logic signed [RW-1:0] SMAX = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  logic                   m1_vld;
  tsqb_pkg::side_t        m1_side;
  logic signed [MW-1:0]   m1_prod;
  tsqb_pkg::side_t        out_side;

  logic signed [SB:0]     diff;
  logic signed [MW-1:0]   prod;
  logic signed [MW-1:0]   w;
  logic signed [RW-1:0]   sum;
  tsqb_pkg::sample_t      blend;
  tsqb_pkg::sample_t      result_next;

  assign diff = (SB+1)'($signed(in_side.hi)) - (SB+1)'($signed(in_side.lo));
  assign prod = MW'($signed({1'b0, f})) * MW'(diff);
  assign w    = m1_prod + HALF;
  assign sum  = RW'($signed(m1_side.lo)) + RW'($signed(w[MW-1:FB]));

  always_comb begin
    if (sum > SMAX) begin
      blend = SMAX[SB-1:0];
    end else if (sum < SMIN) begin
      blend = SMIN[SB-1:0];
    end else begin
      blend = sum[SB-1:0];
    end
    case (m1_side.mode)
      tsqb_pkg::MODE_HIGH:  result_next = m1_side.hi;
      tsqb_pkg::MODE_BLEND: result_next = blend;
      default:              result_next = m1_side.lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      m1_vld  <= in_vld;
      out_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_side  <= in_side;
      m1_prod  <= prod;
      out_side <= m1_side;
      result   <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_blend_between: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_side.mode == tsqb_pkg::MODE_BLEND
      |-> ($signed(result) >= $signed(out_side.lo) && $signed(result) <= $signed(out_side.hi))
       || ($signed(result) <= $signed(out_side.lo) && $signed(result) >= $signed(out_side.hi)))
    else $error("blended result outside the span of its two samples");
`endif

endmodule

>>> src/threshold_select_quintic_blend.sv
// Top level of the threshold select block with quintic blend.
// Depends on tsqb_pkg, tsqb_front, tsqb_div, tsqb_fade and tsqb_mix.
//
// The block takes one request per clock cycle while in_ready is high and returns
// each result after it has passed through the band comparison register, the
// divider stages (one quotient bit per stage, which sets the depth), the quintic
// fade stages and the interpolation and saturation stages. The whole pipeline
// moves as one, so in_ready falls only while a finished result waits at the
// output. The threshold and falloff registers are written through the cfg port
// and may be changed only while no request is in flight.
module threshold_select_quintic_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [tsqb_pkg::SAMPLE_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsqb_pkg::sample_t    control_value,
  input  tsqb_pkg::sample_t    low_value,
  input  tsqb_pkg::sample_t    high_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tsqb_pkg::sample_t    result_value
);

  localparam int SB = tsqb_pkg::SAMPLE_BITS;

  tsqb_pkg::sample_t  threshold;
  tsqb_pkg::falloff_t falloff;
  logic               adv;

  logic               fr_vld;
  tsqb_pkg::side_t    fr_side;
  logic [SB-1:0]      fr_dist;
  logic               fr_sat;
  logic               dv_vld;
  tsqb_pkg::side_t    dv_side;
  tsqb_pkg::frac_t    dv_t;
  logic               fd_vld;
  tsqb_pkg::side_t    fd_side;
  tsqb_pkg::fade_t    fd_f;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      falloff   <= '0;
    end else if (cfg_write) begin
      case (tsqb_pkg::reg_index_t'(cfg_index))
        tsqb_pkg::REG_THRESHOLD: threshold <= cfg_data;
        tsqb_pkg::REG_FALLOFF:   falloff   <= cfg_data[SB-2:0];
        default: ;
      endcase
    end
  end

  tsqb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_vld        (in_valid),
    .control_value (control_value),
    .low_value     (low_value),
    .high_value    (high_value),
    .threshold     (threshold),
    .falloff       (falloff),
    .out_vld       (fr_vld),
    .out_side      (fr_side),
    .offset        (fr_dist),
    .sat           (fr_sat)
  );

  tsqb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .offset   (fr_dist),
    .sat      (fr_sat),
    .falloff  (falloff),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .t        (dv_t)
  );

  tsqb_fade u_fade (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (dv_vld),
    .in_side  (dv_side),
    .t        (dv_t),
    .out_vld  (fd_vld),
    .out_side (fd_side),
    .f        (fd_f)
  );

  tsqb_mix u_mix (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (fd_vld),
    .in_side (fd_side),
    .f       (fd_f),
    .out_vld (out_valid),
    .result  (result_value)
  );

endmodule
